// File: rtl/core/hold_to_trigger_alarm_controller_top_assert.svh
// Assertion macros for the alarm controller checker.
// Each macro expands to one labeled concurrent assertion that is
// clocked on the given clock and disabled while the given reset is high.
`ifndef HOLD_TO_TRIGGER_ALARM_CONTROLLER_TOP_ASSERT_SVH
`define HOLD_TO_TRIGGER_ALARM_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HTAC_ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("alarm controller check failed");

// Next-cycle implication.
`define HTAC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("alarm controller check failed");

`endif

// File: rtl/core/htac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_pkg
// Shared types and constants of the hold-to-trigger alarm controller.
// ----------------------------------------------------------------------------
package htac_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_HOLDING    = 2'd1,
    MODE_TRIGGERED  = 2'd2,
    MODE_CANCELLING = 2'd3
  } mode_t;

  localparam logic [IDX_BITS-1:0] CFG_HOLD_TICKS       = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_CANCEL_TICKS     = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_RELEASE_TICKS    = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_FAST_BLINK_TICKS = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_SLOW_BLINK_TICKS = 3'd4;

  localparam logic [CFG_BITS-1:0] HOLD_TICKS_RST       = 16'd5000;
  localparam logic [CFG_BITS-1:0] CANCEL_TICKS_RST     = 16'd2000;
  localparam logic [CFG_BITS-1:0] RELEASE_TICKS_RST    = 16'd150;
  localparam logic [CFG_BITS-1:0] FAST_BLINK_TICKS_RST = 16'd125;
  localparam logic [CFG_BITS-1:0] SLOW_BLINK_TICKS_RST = 16'd250;

  typedef struct packed {
    logic button_held;
    logic link_up;
    logic remote_trigger;
    logic link_dropped;
  } in_item_t;

  typedef struct packed {
    logic       lamp_on;
    logic [1:0] mode_now;
    logic       send_alarm;
    logic       send_cancel;
    logic       stop_audio;
    logic       alarm_refused;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] hold_ticks;
    logic [CFG_BITS-1:0] cancel_ticks;
    logic [CFG_BITS-1:0] release_ticks;
    logic [CFG_BITS-1:0] fast_blink_ticks;
    logic [CFG_BITS-1:0] slow_blink_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic [COUNT_BITS-1:0] hold_count;
    logic [COUNT_BITS-1:0] release_count;
    logic [COUNT_BITS-1:0] blink_count;
    logic                  blink_phase;
    logic                  lamp_level;
  } ctl_state_t;

endpackage

// File: rtl/core/htac_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_step
// One millisecond tick of the controller: counter advance, link drop,
// remote trigger and the button step of the current mode.
// ----------------------------------------------------------------------------
module htac_step (
  input  htac_pkg::ctl_state_t state,
  input  htac_pkg::cfg_t       cfg,
  input  htac_pkg::in_item_t   item,
  output htac_pkg::ctl_state_t state_next,
  output htac_pkg::out_item_t  result
);

  localparam logic [htac_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  htac_pkg::ctl_state_t s;
  htac_pkg::out_item_t  r;
  logic                 rel_done;

  always_comb begin
    s = state;
    r = '0;

    // advance all counters, saturating
    if (s.hold_count != COUNT_MAX) begin
      s.hold_count = s.hold_count + 1'b1;
    end
    if (s.release_count != COUNT_MAX) begin
      s.release_count = s.release_count + 1'b1;
    end
    if (s.blink_count != COUNT_MAX) begin
      s.blink_count = s.blink_count + 1'b1;
    end
    if (item.button_held) begin
      s.release_count = '0;
    end

    // a drop aborts a first hold
    if (item.link_dropped && s.mode == htac_pkg::MODE_HOLDING) begin
      s.mode       = htac_pkg::MODE_IDLE;
      s.lamp_level = 1'b0;
    end
    if (item.remote_trigger) begin
      r.stop_audio  = 1'b1;
      s.mode        = htac_pkg::MODE_TRIGGERED;
      s.blink_phase = 1'b0;
      s.blink_count = '0;
    end

    rel_done = !item.button_held &&
               (32'(s.release_count) >= 32'(cfg.release_ticks));

    case (s.mode)
      htac_pkg::MODE_IDLE: begin
        if (item.button_held) begin
          s.mode          = htac_pkg::MODE_HOLDING;
          s.hold_count    = '0;
          s.release_count = '0;
          s.lamp_level    = 1'b1;
        end else begin
          s.lamp_level = 1'b0;
        end
      end
      htac_pkg::MODE_HOLDING: begin
        if (rel_done) begin
          s.mode       = htac_pkg::MODE_IDLE;
          s.lamp_level = 1'b0;
        end else if (32'(s.hold_count) >= 32'(cfg.hold_ticks)) begin
          if (!item.link_up) begin
            s.mode          = htac_pkg::MODE_IDLE;
            s.lamp_level    = 1'b0;
            r.alarm_refused = 1'b1;
          end else begin
            r.send_alarm  = 1'b1;
            r.stop_audio  = 1'b1;
            s.mode        = htac_pkg::MODE_TRIGGERED;
            s.blink_phase = 1'b0;
            s.blink_count = '0;
          end
        end
      end
      htac_pkg::MODE_TRIGGERED: begin
        if (32'(s.blink_count) >= 32'(cfg.fast_blink_ticks)) begin
          s.blink_count = '0;
          s.blink_phase = !s.blink_phase;
          s.lamp_level  = s.blink_phase;
        end
        if (item.button_held) begin
          s.mode          = htac_pkg::MODE_CANCELLING;
          s.hold_count    = '0;
          s.release_count = '0;
        end
      end
      default: begin
        if (rel_done) begin
          s.mode        = htac_pkg::MODE_TRIGGERED;
          s.blink_count = '0;
        end else begin
          if (32'(s.blink_count) >= 32'(cfg.slow_blink_ticks)) begin
            s.blink_count = '0;
            s.blink_phase = !s.blink_phase;
            s.lamp_level  = s.blink_phase;
          end
          if (32'(s.hold_count) >= 32'(cfg.cancel_ticks)) begin
            s.mode        = htac_pkg::MODE_IDLE;
            s.lamp_level  = 1'b0;
            r.stop_audio  = 1'b1;
            r.send_cancel = item.link_up;
          end
        end
      end
    endcase

    r.lamp_on  = s.lamp_level;
    r.mode_now = s.mode;
  end

  assign state_next = s;
  assign result     = r;

endmodule

// File: rtl/core/hold_to_trigger_alarm_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hold_to_trigger_alarm_controller_top
// A tick transaction passes through the input register, then the result register.
// Throughput: one tick per cycle unless the output stalls; the state loop is one pass of htac_step.
// Input stalls only while the input register is full and the result is held.
// Synchronous reset clears the state, both stages and loads register defaults.
// ----------------------------------------------------------------------------
module hold_to_trigger_alarm_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  htac_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output htac_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [htac_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [htac_pkg::CFG_BITS-1:0]     cfg_data
);

  htac_pkg::cfg_t       cfg;
  htac_pkg::ctl_state_t state;
  htac_pkg::ctl_state_t state_next;
  htac_pkg::in_item_t   s1_data;
  logic                 s1_valid;
  htac_pkg::out_item_t  step_result;
  logic                 out_open;
  logic                 advance;

  assign out_open = !out_valid || !out_stall;
  assign advance  = s1_valid && out_open;
  assign in_stall = s1_valid && !out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks       <= htac_pkg::HOLD_TICKS_RST;
      cfg.cancel_ticks     <= htac_pkg::CANCEL_TICKS_RST;
      cfg.release_ticks    <= htac_pkg::RELEASE_TICKS_RST;
      cfg.fast_blink_ticks <= htac_pkg::FAST_BLINK_TICKS_RST;
      cfg.slow_blink_ticks <= htac_pkg::SLOW_BLINK_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        htac_pkg::CFG_HOLD_TICKS:       cfg.hold_ticks       <= cfg_data;
        htac_pkg::CFG_CANCEL_TICKS:     cfg.cancel_ticks     <= cfg_data;
        htac_pkg::CFG_RELEASE_TICKS:    cfg.release_ticks    <= cfg_data;
        htac_pkg::CFG_FAST_BLINK_TICKS: cfg.fast_blink_ticks <= cfg_data;
        htac_pkg::CFG_SLOW_BLINK_TICKS: cfg.slow_blink_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  htac_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (s1_data),
    .state_next (state_next),
    .result     (step_result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // state advances only when the tick moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= htac_pkg::MODE_IDLE;
      state.hold_count    <= '0;
      state.release_count <= '0;
      state.blink_count   <= '0;
      state.blink_phase   <= 1'b0;
      state.lamp_level    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

// File: rtl/core/htac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htac_checker
// Port-level checks of the alarm controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "hold_to_trigger_alarm_controller_top_assert.svh"

module htac_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input htac_pkg::out_item_t out_data
);

  logic alarm_ok;
  logic cancel_ok;
  logic idle_ok;
  logic hold_ok;

  // alarm report comes with the triggered mode and a stop of playback
  assign alarm_ok  = !out_data.send_alarm ||
                     (out_data.mode_now == htac_pkg::MODE_TRIGGERED && out_data.stop_audio);
  // cancel report and refusal both leave the block idle
  assign cancel_ok = !(out_data.send_cancel || out_data.alarm_refused) ||
                     out_data.mode_now == htac_pkg::MODE_IDLE;
  // lamp is dark when idle and lit during a first hold
  assign idle_ok   = !(out_data.mode_now == htac_pkg::MODE_IDLE && out_data.lamp_on);
  assign hold_ok   = out_data.mode_now != htac_pkg::MODE_HOLDING || out_data.lamp_on;

  `HTAC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `HTAC_ASSERT_IMPLY(a_alarm_mode, clk, rst, out_valid, alarm_ok)
  `HTAC_ASSERT_IMPLY(a_cancel_idle, clk, rst, out_valid, cancel_ok)
  `HTAC_ASSERT_IMPLY(a_idle_dark, clk, rst, out_valid, idle_ok)
  `HTAC_ASSERT_IMPLY(a_hold_lit, clk, rst, out_valid, hold_ok)

endmodule

bind hold_to_trigger_alarm_controller_top htac_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
